// File: rtl/dtp_pkg.sv
// Shared types, constants and lookup functions for the date/time string parser.
// Used by dtp_front, dtp_queue, dtp_back and datetime_string_parser.
package dtp_pkg;

  localparam int unsigned StrLen     = 19;
  localparam int unsigned OverrunPos = 20;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned NumFields  = 7;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNull  = 8'h00;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_NO_TERM = 3'd2,
    ST_DOT1    = 3'd3,
    ST_DOT2    = 3'd4,
    ST_COLON1  = 3'd5,
    ST_COLON2  = 3'd6
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year_hi;
    logic [7:0] year_lo;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
    logic       tens;
  } slot_t;

  function automatic slot_t slot_of(logic [4:0] p);
    slot_t s;
    s = '{valid: 1'b0, slot: 3'd0, tens: 1'b0};
    case (p)
      5'd0:  s = '{valid: 1'b1, slot: 3'd0, tens: 1'b1};
      5'd1:  s = '{valid: 1'b1, slot: 3'd0, tens: 1'b0};
      5'd3:  s = '{valid: 1'b1, slot: 3'd1, tens: 1'b1};
      5'd4:  s = '{valid: 1'b1, slot: 3'd1, tens: 1'b0};
      5'd6:  s = '{valid: 1'b1, slot: 3'd2, tens: 1'b1};
      5'd7:  s = '{valid: 1'b1, slot: 3'd2, tens: 1'b0};
      5'd8:  s = '{valid: 1'b1, slot: 3'd3, tens: 1'b1};
      5'd9:  s = '{valid: 1'b1, slot: 3'd3, tens: 1'b0};
      5'd11: s = '{valid: 1'b1, slot: 3'd4, tens: 1'b1};
      5'd12: s = '{valid: 1'b1, slot: 3'd4, tens: 1'b0};
      5'd14: s = '{valid: 1'b1, slot: 3'd5, tens: 1'b1};
      5'd15: s = '{valid: 1'b1, slot: 3'd5, tens: 1'b0};
      5'd17: s = '{valid: 1'b1, slot: 3'd6, tens: 1'b1};
      5'd18: s = '{valid: 1'b1, slot: 3'd6, tens: 1'b0};
      default: s = '{valid: 1'b0, slot: 3'd0, tens: 1'b0};
    endcase
    return s;
  endfunction

  // days before month m, counted from March: (m*306+5)/10
  function automatic logic [8:0] month_offset(logic [3:0] m);
    logic [8:0] r;
    r = 9'd0;
    case (m)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd31;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd92;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd184;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd245;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/datetime_string_parser.sv
// Top level of the date/time string parser: front end, job queue, weekday back end.
// Depends on dtp_pkg, dtp_front, dtp_queue and dtp_back.
//
// Usage:
//   s_axis carries one character byte per item in tdata[7:0]. The string is
//   "dd.mm.yyyy HH:MM:SS"; a zero byte ends it and produces exactly one result
//   on m_axis. Non-zero bytes produce no result; bytes past the last seconds
//   digit are dropped until the zero byte.
//   m_axis tdata carries status, date, time and weekday (1 Monday .. 7 Sunday);
//   on any error status all fields except status read zero.
//   Throughput: one byte per cycle. s_axis_tready falls only when the 4-entry
//   job queue is full, which takes four jobs waiting in the queue behind a
//   back end frozen by a stalled m_axis.
//   Path: the result for a terminator is written to the job queue, then
//   passes the back end, a six-stage pipeline (year multiply, month reduce,
//   x365 and /100 multiply, day-number add, /7 reciprocal multiply, output
//   register).
//   A stalled m_axis holds its result and freezes the back end; the front end
//   keeps taking bytes while the queue has room.
//   Reset (rst, synchronous, active high) clears position, separator state,
//   the queue and all pipeline valids.
module datetime_string_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [2:0] status, [10:3] day_of_month,
                                      // [18:11] month_value, [34:19] year_value,
                                      // [37:35] weekday, [45:38] hour_value,
                                      // [53:46] minute_value, [61:54] second_value
);

  logic          queue_full;
  logic          push;
  dtp_pkg::job_t push_job;
  logic          pop;
  logic          q_valid;
  dtp_pkg::job_t head;
  dtp_pkg::job_t out_job;
  logic [2:0]    out_weekday;
  logic [15:0]   year_value;

  dtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  dtp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  dtp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_job     (out_job),
    .out_weekday (out_weekday)
  );

  assign year_value = 16'({8'd0, out_job.year_hi} * 16'd100) + {8'd0, out_job.year_lo};

  assign m_axis_tdata = {2'b00,
                         out_job.second,
                         out_job.minute,
                         out_job.hour,
                         out_weekday,
                         year_value,
                         out_job.month,
                         out_job.day,
                         out_job.status};

endmodule

// File: rtl/dtp_front.sv
// Character front end: tracks position, accumulates digit pairs, checks separators.
// Emits one job per terminating null into the queue. Depends on dtp_pkg.
module dtp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char,
  input  logic          queue_full,
  output logic          push,
  output dtp_pkg::job_t push_job
);

  logic [4:0]           position;
  logic [4:0]           position_next;
  dtp_pkg::status_t     sep_err;
  dtp_pkg::status_t     sep_err_next;
  logic [7:0]           acc [dtp_pkg::NumFields];
  dtp_pkg::slot_t       cur_slot;
  logic [7:0]           digit;
  logic                 accept;
  logic                 is_null;
  dtp_pkg::status_t     st;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_null  = (in_char == dtp_pkg::CharNull);
  assign push     = accept && is_null;
  assign cur_slot = dtp_pkg::slot_of(position);
  assign digit    = in_char - dtp_pkg::CharZero;

  always_comb begin
    position_next = position;
    sep_err_next  = sep_err;
    if (accept) begin
      if (is_null) begin
        position_next = 5'd0;
        sep_err_next  = dtp_pkg::ST_OK;
      end else if (position < 5'(dtp_pkg::StrLen)) begin
        position_next = position + 5'd1;
        if (!cur_slot.valid && sep_err == dtp_pkg::ST_OK) begin
          case (position)
            5'd2:  if (in_char != dtp_pkg::CharDot) sep_err_next = dtp_pkg::ST_DOT1;
            5'd5:  if (in_char != dtp_pkg::CharDot) sep_err_next = dtp_pkg::ST_DOT2;
            5'd13: if (in_char != dtp_pkg::CharColon) sep_err_next = dtp_pkg::ST_COLON1;
            5'd16: if (in_char != dtp_pkg::CharColon) sep_err_next = dtp_pkg::ST_COLON2;
            default: sep_err_next = sep_err;
          endcase
        end
      end else begin
        position_next = 5'(dtp_pkg::OverrunPos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 5'd0;
      sep_err  <= dtp_pkg::ST_OK;
    end else begin
      position <= position_next;
      sep_err  <= sep_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_null && position < 5'(dtp_pkg::StrLen) && cur_slot.valid) begin
      if (cur_slot.tens) begin
        acc[cur_slot.slot] <= {digit[4:0], 3'b000} + {digit[6:0], 1'b0};
      end else begin
        acc[cur_slot.slot] <= acc[cur_slot.slot] + digit;
      end
    end
  end

  always_comb begin
    if (position < 5'(dtp_pkg::StrLen)) begin
      st = dtp_pkg::ST_SHORT;
    end else if (position >= 5'(dtp_pkg::OverrunPos)) begin
      st = dtp_pkg::ST_NO_TERM;
    end else begin
      st = sep_err;
    end
    push_job.status = st;
    if (st == dtp_pkg::ST_OK) begin
      push_job.day     = acc[0];
      push_job.month   = acc[1];
      push_job.year_hi = acc[2];
      push_job.year_lo = acc[3];
      push_job.hour    = acc[4];
      push_job.minute  = acc[5];
      push_job.second  = acc[6];
    end else begin
      push_job.day     = 8'd0;
      push_job.month   = 8'd0;
      push_job.year_hi = 8'd0;
      push_job.year_lo = 8'd0;
      push_job.hour    = 8'd0;
      push_job.minute  = 8'd0;
      push_job.second  = 8'd0;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= 5'(dtp_pkg::OverrunPos))
    else $error("position out of range");

  a_null_resets: assert property (@(posedge clk) disable iff (rst)
    push |=> (position == 5'd0 && sep_err == dtp_pkg::ST_OK))
    else $error("state not cleared after terminator");

endmodule

// File: rtl/dtp_queue.sv
// Short job queue between the character front end and the weekday back end.
// Depends on dtp_pkg for the job type and depth.
module dtp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dtp_pkg::job_t head
);

  dtp_pkg::job_t                 mem [dtp_pkg::QueueDepth];
  logic [dtp_pkg::QueueAw-1:0]   wr_ptr;
  logic [dtp_pkg::QueueAw-1:0]   rd_ptr;
  logic [dtp_pkg::QueueAw:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count == (dtp_pkg::QueueAw+1)'(dtp_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (dtp_pkg::QueueAw+1)'(dtp_pkg::QueueDepth))
    else $error("queue count overflow");

endmodule

// File: rtl/dtp_back.sv
// Weekday back end: pipelined year, March-based day number and mod-7 reduction,
// ending in the output register. Depends on dtp_pkg.
module dtp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  dtp_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output dtp_pkg::job_t out_job,
  output logic [2:0]    out_weekday
);

  logic          adv;
  logic          v1, v2, v3, v4, v5;
  dtp_pkg::job_t j1, j2, j3, j4, j5;

  logic [15:0]   yr1;
  logic [8:0]    mv1;
  logic [4:0]    q12_1;
  logic [15:0]   yr_next;
  logic [8:0]    mv_next;
  logic [16:0]   mv_prod;

  logic [15:0]   y2;
  logic [8:0]    moff2;
  logic [8:0]    mrem;
  logic [3:0]    m_next;

  logic [24:0]   y365_3;
  logic [9:0]    c100_3;
  logic [13:0]   y4_3;
  logic [8:0]    moff3;
  logic [26:0]   prod100;

  logic [24:0]   dn4;
  logic [24:0]   dn_next;

  logic [22:0]   q7_5;
  logic [24:0]   dn5;
  logic [50:0]   prod7;

  logic [25:0]   q7x7;
  logic [24:0]   rem7;
  logic [2:0]    wd_next;

  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  assign yr_next = 16'({8'd0, head.year_hi} * 16'd100) + {8'd0, head.year_lo};
  assign mv_next = {1'b0, head.month} + 9'd9;
  assign mv_prod = mv_next * 17'd171;

  assign mrem   = mv1 - ({2'b00, q12_1, 2'b00} + {1'b0, q12_1, 3'b000});
  assign m_next = mrem[3:0];

  assign prod100 = {13'd0, y2[15:2]} * 27'd5243;

  assign dn_next = y365_3 + {11'd0, y4_3} - {15'd0, c100_3} + {17'd0, c100_3[9:2]}
                 + {16'd0, moff3} + {17'd0, j3.day} + 25'd2;

  assign prod7 = {26'd0, dn4} * 51'd38347923;

  assign q7x7 = {q7_5, 3'b000} - {3'b000, q7_5};
  assign rem7 = dn5 - q7x7[24:0];

  always_comb begin
    if (j5.status != dtp_pkg::ST_OK) begin
      wd_next = 3'd0;
    end else if (rem7[2:0] == 3'd0) begin
      wd_next = 3'd7;
    end else begin
      wd_next = rem7[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1      <= head;
      yr1     <= yr_next;
      mv1     <= mv_next;
      q12_1   <= mv_prod[15:11];

      j2      <= j1;
      y2      <= yr1 - {15'd0, (m_next >= 4'd10)};
      moff2   <= dtp_pkg::month_offset(m_next);

      j3      <= j2;
      y365_3  <= 25'(y2 * 25'd365);
      c100_3  <= prod100[26:17];
      y4_3    <= y2[15:2];
      moff3   <= moff2;

      j4      <= j3;
      dn4     <= dn_next;

      j5      <= j4;
      dn5     <= dn4;
      q7_5    <= prod7[50:28];

      out_job     <= j5;
      out_weekday <= wd_next;
    end
  end

  a_weekday_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_job.status == dtp_pkg::ST_OK) == (out_weekday != 3'd0)))
    else $error("weekday inconsistent with status");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_weekday)))
    else $error("output changed while stalled");

endmodule
